// ----- rtl/core/sfa_pkg.sv -----
// Shared types, codes and defaults of the strided frame allocator.
package sfa_pkg;

  localparam int FRAME_COUNT_DEF = 1024;
  localparam int MAX_BATCH_DEF   = 16;
  localparam int RESERVED_RST    = 256;

  localparam int OP_W     = 2;
  localparam int FRAME_W  = 10;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int RES_W    = 11;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOFRAMES = 2'd1,
    ST_IGNORED  = 2'd2
  } status_t;

  typedef struct packed {
    logic    start;
    logic    sweep_en;
    logic    scan_en;
    logic    free_wr;
    logic    emit_en;
    logic    resp_ld;
    status_t resp_status;
  } sfa_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_over;
    logic free_ok;
    logic sweep_done;
    logic scan_full;
    logic scan_dry;
    logic emit_last;
  } sfa_sts_t;

endpackage

// ----- rtl/core/sfa_dpath.sv -----
// Datapath of the frame allocator: frame map memory, scan and sweep counters, pick list, output.
module sfa_dpath import sfa_pkg::*; #(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int MAX_BATCH   = MAX_BATCH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [RES_W-1:0]    cfg_wdata,
  input  logic [FRAME_W-1:0]  in_frame,
  input  logic [COUNT_W-1:0]  in_count,
  input  sfa_cmd_t            cmd,
  output sfa_sts_t            sts,
  output logic [STATUS_W-1:0] out_status,
  output logic [FRAME_W-1:0]  out_frame_res,
  output logic                out_last
);

  localparam int FW    = $clog2(FRAME_COUNT);
  localparam int CW    = FW + 1;
  localparam int CNTW  = $clog2(MAX_BATCH + 1);
  localparam int PW    = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int R_RST = (RESERVED_RST > FRAME_COUNT) ? FRAME_COUNT : RESERVED_RST;

  logic                mem [FRAME_COUNT];
  logic [RES_W-1:0]    reserved_r;
  logic [CW-1:0]       r_lat_r;
  logic [FW-1:0]       sweep_r;
  logic [CW-1:0]       scan_r;
  logic                rd_pend_r;
  logic [FW-1:0]       rd_idx_r;
  logic                rd_data_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic [CNTW-1:0]     found_r;
  logic [FW-1:0]       picks_r [MAX_BATCH];
  logic [STATUS_W-1:0] out_status_r;
  logic [FRAME_W-1:0]  out_frame_r;
  logic                out_last_r;

  logic [CW-1:0]       r_eff;
  logic                in_range;
  logic                hit;
  logic [FW-1:0]       free_addr;
  logic                wr_en;
  logic [FW-1:0]       wr_addr;
  logic                wr_data;

  assign r_eff     = (32'(reserved_r) > 32'(FRAME_COUNT)) ? CW'(FRAME_COUNT) : CW'(reserved_r);
  assign in_range  = 32'(scan_r) < 32'(FRAME_COUNT);
  assign hit       = rd_pend_r && !rd_data_r && (32'(found_r) < 32'(cnt_r));
  assign free_addr = FW'(32'(in_frame));

  assign sts.cnt_zero   = (in_count == '0);
  assign sts.cnt_over   = 32'(in_count) > 32'(MAX_BATCH);
  assign sts.free_ok    = (32'(in_frame) >= 32'(r_eff)) && (32'(in_frame) < 32'(FRAME_COUNT));
  assign sts.sweep_done = 32'(sweep_r) == 32'(FRAME_COUNT - 1);
  assign sts.scan_full  = 32'(found_r) == 32'(cnt_r);
  assign sts.scan_dry   = !in_range && !rd_pend_r;
  assign sts.emit_last  = 32'(found_r) == 32'd1;

  // One write port shared by the sweep, frees and committed picks.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep_r;
    wr_data = 1'b0;
    priority if (cmd.sweep_en) begin
      wr_en   = 1'b1;
      wr_addr = sweep_r;
      wr_data = 32'(sweep_r) < 32'(r_lat_r);
    end else if (cmd.free_wr) begin
      wr_en   = 1'b1;
      wr_addr = free_addr;
      wr_data = 1'b0;
    end else if (cmd.emit_en) begin
      wr_en   = 1'b1;
      wr_addr = picks_r[0];
      wr_data = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= RES_W'(RESERVED_RST);
      r_lat_r    <= CW'(R_RST);
      sweep_r    <= '0;
      scan_r     <= '0;
      rd_pend_r  <= 1'b0;
      found_r    <= '0;
    end else begin
      if (cfg_we) begin
        reserved_r <= cfg_wdata;
      end
      if (cmd.start) begin
        r_lat_r   <= r_eff;
        sweep_r   <= '0;
        scan_r    <= r_eff;
        rd_pend_r <= 1'b0;
        found_r   <= '0;
      end
      if (cmd.sweep_en) begin
        sweep_r <= sweep_r + FW'(1);
      end
      if (cmd.scan_en) begin
        rd_pend_r <= in_range;
        if (in_range) begin
          scan_r <= scan_r + CW'(2);
        end
        if (hit) begin
          found_r <= found_r + CNTW'(1);
        end
      end
      if (cmd.emit_en) begin
        found_r <= found_r - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt_r <= in_count;
    end
    if (cmd.scan_en) begin
      if (in_range) begin
        rd_idx_r  <= scan_r[FW-1:0];
        rd_data_r <= mem[scan_r[FW-1:0]];
      end
      if (hit) begin
        picks_r[found_r[PW-1:0]] <= rd_idx_r;
      end
    end
    if (cmd.emit_en) begin
      for (int j = 0; j < MAX_BATCH - 1; j++) begin
        picks_r[j] <= picks_r[j+1];
      end
      out_status_r <= ST_OK;
      out_frame_r  <= FRAME_W'(32'(picks_r[0]));
      out_last_r   <= sts.emit_last;
    end
    if (cmd.resp_ld) begin
      out_status_r <= cmd.resp_status;
      out_frame_r  <= '0;
      out_last_r   <= 1'b1;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign out_status    = out_status_r;
  assign out_frame_res = out_frame_r;
  assign out_last      = out_last_r;

endmodule

// ----- rtl/core/sfa_ctrl.sv -----
// Controller of the frame allocator: request decode, sequencing and output valid.
module sfa_ctrl import sfa_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] in_op,
  output logic            out_valid,
  input  logic            out_ready,
  input  sfa_sts_t        sts,
  output sfa_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_SCAN,
    S_EMIT,
    S_RESP
  } state_t;

  state_t  state_r, state_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    boot_r, boot_nxt;
  status_t resp_r, resp_nxt;
  logic    accept;
  logic    slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt       = state_r;
    boot_nxt        = boot_r;
    resp_nxt        = resp_r;
    cmd             = '0;
    cmd.resp_status = resp_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.start = 1'b1;
          unique case (op_t'(in_op))
            OP_INIT: begin
              resp_nxt  = ST_OK;
              state_nxt = S_SWEEP;
            end
            OP_ALLOC: begin
              priority if (sts.cnt_zero) begin
                resp_nxt  = ST_OK;
                state_nxt = S_RESP;
              end else if (sts.cnt_over) begin
                resp_nxt  = ST_NOFRAMES;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_FREE: begin
              cmd.free_wr = sts.free_ok;
              if (sts.free_ok) begin
                resp_nxt = ST_OK;
              end else begin
                resp_nxt = ST_IGNORED;
              end
              state_nxt = S_RESP;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SWEEP: begin
        cmd.sweep_en = 1'b1;
        if (sts.sweep_done) begin
          boot_nxt  = 1'b0;
          state_nxt = boot_r ? S_IDLE : S_RESP;
        end
      end
      S_SCAN: begin
        priority if (sts.scan_full) begin
          state_nxt = S_EMIT;
        end else if (sts.scan_dry) begin
          resp_nxt  = ST_NOFRAMES;
          state_nxt = S_RESP;
        end else begin
          cmd.scan_en = 1'b1;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit_en = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          cmd.resp_ld = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.emit_en || cmd.resp_ld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      boot_r      <= 1'b1;
      out_valid_r <= 1'b0;
      resp_r      <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      out_valid_r <= out_valid_nxt;
      resp_r      <= resp_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/strided_frame_allocator.sv -----
// Top level of the strided first-fit frame allocator.
// Usage: a request on the in_ channel carries an op (init, allocate or free), a frame number
// for free and a frame count for allocate. Results leave on the out_ channel: one result per
// init, free or zero-count or refused allocate, one per granted frame in ascending order,
// with out_last marking the final result of the request. Both channels use valid/ready.
// The cfg_ port writes the reserved frame count; it takes effect at the next request and
// does not touch the frame map by itself.
// A free or a zero or oversized allocate goes straight to its response; an init first
// sweeps the whole map, writing one entry per cycle. An allocate scans the map from the
// first free-able frame at stride two, one entry per cycle through the single memory read
// port, and answers with a refusal when the scan runs dry or with the batch once enough
// free frames are found.
// One request is worked on at a time; the next is taken once the last result of the previous
// one sits in the output register, even if the receiver has not yet taken it.
// After reset the block sweeps the whole map with in_ready low, marking the first 256
// frames used; configuration writes are taken during the sweep.
// A receiver stall holds the output register and pauses the batch; nothing is lost.
module strided_frame_allocator import sfa_pkg::*; #(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int MAX_BATCH   = MAX_BATCH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [FRAME_W-1:0]  in_frame,
  input  logic [COUNT_W-1:0]  in_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [FRAME_W-1:0]  out_frame_res,
  output logic                out_last,
  input  logic                cfg_we,
  input  logic [RES_W-1:0]    cfg_wdata
);

  sfa_cmd_t cmd;
  sfa_sts_t sts;

  // The controller sequences each request and owns the output valid flag.
  sfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the frame map, the scan state, the pick list and the output payload.
  sfa_dpath #(
    .FRAME_COUNT (FRAME_COUNT),
    .MAX_BATCH   (MAX_BATCH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_frame      (in_frame),
    .in_count      (in_count),
    .cmd           (cmd),
    .sts           (sts),
    .out_status    (out_status),
    .out_frame_res (out_frame_res),
    .out_last      (out_last)
  );

  // A result that is not the last one of its request is always a granted frame.
  a_mid_batch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_OK)
    else $error("non-final result carries a failure status");

  // Failure and ignore results never carry a frame number.
  a_fail_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_frame_res == '0)
    else $error("failure result carries a frame number");

  // Once a granted frame is taken, the next frame of the batch follows at once.
  a_batch_streams: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside an allocation batch");

  // A new request is never taken while a batch is still being delivered.
  a_no_accept_mid_batch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !(out_valid && !out_last))
    else $error("request accepted in the middle of a batch");

endmodule

// ----- bench/tb_strided_frame_allocator.sv -----
// Self-checking testbench for the strided first-fit frame allocator.
`timescale 1ns / 1ps

module tb_strided_frame_allocator import sfa_pkg::*; ();

  localparam int FRAME_COUNT = FRAME_COUNT_DEF;
  localparam int MAX_BATCH   = MAX_BATCH_DEF;

  // Op code 3 has no name in the package; the block must swallow it silently.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // The long receiver hold-off of the pressure phase, in cycles.
  localparam int HOLD_CYCLES    = 400;
  // An init sweeps the whole map and an allocate can scan half of it, so this many quiet
  // cycles are allowed before a register write and at the end.
  localparam int SETTLE_CYCLES  = 1200;
  // Longest correct stretch without any accepted request or result is an init, a settle
  // pause or the reset sweep plus receiver stalls; the limit is many times that.
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD} idle_mode_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame_res;
    logic                last;
  } result_t;

  // One directed request. Where typed is set, the single result is written in the row
  // and last is always 1; other rows are checked against the frame map predictor.
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [FRAME_W-1:0]  frame;
    logic [COUNT_W-1:0]  count;
    logic                typed;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame_res;
  } directed_row_t;

  localparam int DIR_ROWS = 21;
  localparam directed_row_t DIRECTED [DIR_ROWS] = '{
    // Right after reset the first allocatable frame is 256.
    '{OP_ALLOC,  10'd0,    5'd1,  1'b1, ST_OK,       10'd256},
    // A full batch walks 258, 260, ... at stride two.
    '{OP_ALLOC,  10'd0,    5'd16, 1'b0, ST_OK,       10'd0},
    // A zero count takes nothing but still answers ok.
    '{OP_ALLOC,  10'd0,    5'd0,  1'b1, ST_OK,       10'd0},
    // Counts above the batch limit are refused outright.
    '{OP_ALLOC,  10'd0,    5'd17, 1'b1, ST_NOFRAMES, 10'd0},
    '{OP_ALLOC,  10'd1023, 5'd31, 1'b1, ST_NOFRAMES, 10'd0},
    // Frees inside the reserved area are ignored.
    '{OP_FREE,   10'd0,    5'd0,  1'b1, ST_IGNORED,  10'd0},
    '{OP_FREE,   10'd255,  5'd0,  1'b1, ST_IGNORED,  10'd0},
    // The first allocatable frame may be freed.
    '{OP_FREE,   10'd256,  5'd0,  1'b1, ST_OK,       10'd0},
    // Freeing frames that are already free is allowed.
    '{OP_FREE,   10'd1023, 5'd0,  1'b1, ST_OK,       10'd0},
    '{OP_FREE,   10'd682,  5'd31, 1'b1, ST_OK,       10'd0},
    '{OP_FREE,   10'd341,  5'd0,  1'b1, ST_OK,       10'd0},
    // The unused op code gives no result at all.
    '{OP_UNUSED, 10'd1023, 5'd31, 1'b0, ST_OK,       10'd0},
    // Frame 256 was freed above, so it is handed out again.
    '{OP_ALLOC,  10'd0,    5'd1,  1'b0, ST_OK,       10'd0},
    '{OP_ALLOC,  10'd0,    5'd2,  1'b0, ST_OK,       10'd0},
    // A hole in the middle of the granted run is refilled first.
    '{OP_FREE,   10'd258,  5'd0,  1'b1, ST_OK,       10'd0},
    '{OP_ALLOC,  10'd0,    5'd16, 1'b0, ST_OK,       10'd0},
    // Init frees everything above the reserved area.
    '{OP_INIT,   10'd0,    5'd0,  1'b1, ST_OK,       10'd0},
    '{OP_ALLOC,  10'd0,    5'd1,  1'b1, ST_OK,       10'd256},
    '{OP_ALLOC,  10'd682,  5'd16, 1'b0, ST_OK,       10'd0},
    '{OP_ALLOC,  10'd0,    5'd8,  1'b0, ST_OK,       10'd0},
    '{OP_FREE,   10'd256,  5'd0,  1'b1, ST_OK,       10'd0}
  };

  // Random phases: the reserved count written before each, how both sides idle, and how
  // many requests are offered. The extremes 0 and 2047 (clamped to FRAME_COUNT) are here,
  // as are settings that leave only a few frames, so that allocations run dry.
  localparam int NUM_PHASES = 9;
  localparam logic [RES_W-1:0] PHASE_RESERVED [NUM_PHASES] = '{
    11'd256, 11'd256, 11'd1000, 11'd0, 11'd777, 11'd2047, 11'd1023, 11'd1024, 11'd600
  };
  localparam idle_mode_t PHASE_IDLE [NUM_PHASES] = '{
    IDLE_HOLD, IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_RECV, IDLE_SEND,
    IDLE_BOTH
  };
  localparam int PHASE_ITEMS [NUM_PHASES] = '{20, 45, 40, 50, 45, 15, 30, 15, 50};

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     in_op;
  logic [FRAME_W-1:0]  in_frame;
  logic [COUNT_W-1:0]  in_count;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [FRAME_W-1:0]  out_frame_res;
  logic                out_last;
  logic                cfg_we;
  logic [RES_W-1:0]    cfg_wdata;

  // Predictor state: its own copy of the used/free map and of the reserved count.
  bit               frame_used [FRAME_COUNT];
  logic [RES_W-1:0] reserved_cfg;
  result_t          step_results [MAX_BATCH];
  // Frames the predictor has granted since the last init; most random frees draw from them.
  int               granted_frames [$];
  // Results the block still owes, oldest first.
  result_t          due_results [$];

  idle_mode_t idle_mode;
  int         quiet_cycles;
  int         mismatches;
  int         requests_sent;
  int         results_seen;
  int         refusals;
  int         ignored_frees;

  strided_frame_allocator #(
    .FRAME_COUNT(FRAME_COUNT),
    .MAX_BATCH  (MAX_BATCH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_frame     (in_frame),
    .in_count     (in_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_frame_res(out_frame_res),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one accepted request to the predicted map and leaves its results in
  // step_results; returns how many results the request causes.
  function automatic int frame_map_step(input logic [OP_W-1:0] op,
                                        input logic [FRAME_W-1:0] frame,
                                        input logic [COUNT_W-1:0] count);
    int base;
    int found;
    // The reserved count saturates at the size of the map.
    base = (reserved_cfg > FRAME_COUNT) ? FRAME_COUNT : int'(reserved_cfg);
    found = 0;
    step_results[0] = '{ST_OK, 10'd0, 1'b1};
    case (op)
      OP_INIT: begin
        for (int i = 0; i < FRAME_COUNT; i++) frame_used[i] = (i < base);
        granted_frames.delete();
        return 1;
      end
      OP_ALLOC: begin
        if (count == 0) return 1;
        if (count > MAX_BATCH) begin
          step_results[0].status = ST_NOFRAMES;
          return 1;
        end
        // First fit at stride two from the first non-reserved frame.
        for (int i = base; i < FRAME_COUNT && found < count; i += 2) begin
          if (!frame_used[i]) begin
            step_results[found] = '{ST_OK, FRAME_W'(i), 1'b0};
            found++;
          end
        end
        // All or nothing: a short scan takes no frame at all.
        if (found < count) begin
          step_results[0] = '{ST_NOFRAMES, 10'd0, 1'b1};
          return 1;
        end
        for (int k = 0; k < found; k++) begin
          frame_used[step_results[k].frame_res] = 1'b1;
          granted_frames.push_back(int'(step_results[k].frame_res));
        end
        step_results[found - 1].last = 1'b1;
        return found;
      end
      OP_FREE: begin
        // A 10-bit frame is always below FRAME_COUNT, so only the reserved bound matters.
        if (frame >= base) frame_used[frame] = 1'b0;
        else step_results[0].status = ST_IGNORED;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 62;
      IDLE_BOTH: return $urandom_range(99) < 33;
      default:   return 1'b0;
    endcase
  endfunction

  // Offers one request at the falling edge, after any idle cycles, holds it until it is
  // taken, then books the results it should cause. A typed row books its written result.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] frame,
                              input logic [COUNT_W-1:0] count, input bit typed,
                              input result_t typed_res);
    int n;
    @(negedge clk);
    while (sender_rests()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_op    = op;
    in_frame = frame;
    in_count = count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = frame_map_step(op, frame, count);
    requests_sent++;
    if (typed) due_results.push_back(typed_res);
    else for (int k = 0; k < n; k++) due_results.push_back(step_results[k]);
  endtask

  // Stops offering requests and waits until every booked result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Register writes only land on an idle block: drained, and then given time to finish
  // any request that produces no result.
  task automatic settle_and_configure(input logic [RES_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we       = 1'b0;
    reserved_cfg = value;
  endtask

  // The receiver changes out_ready at falling edges. In the hold phase it refuses results
  // for a long stretch, counted here, while the sender keeps offering requests.
  initial begin
    idle_mode_t mode_seen;
    int         hold_count;
    out_ready  = 1'b1;
    mode_seen  = IDLE_NONE;
    hold_count = 0;
    forever begin
      @(negedge clk);
      if (idle_mode != mode_seen) begin
        mode_seen  = idle_mode;
        hold_count = 0;
      end
      case (idle_mode)
        IDLE_HOLD: begin
          out_ready = (hold_count >= HOLD_CYCLES);
          if (!out_ready) hold_count++;
        end
        IDLE_RECV: out_ready = ($urandom_range(99) >= 62);
        IDLE_BOTH: out_ready = ($urandom_range(99) >= 33);
        default:   out_ready = 1'b1;
      endcase
    end
  end

  // Result checker: every taken result is matched against the oldest booked one.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) quiet_cycles = 0;
    else quiet_cycles++;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_status == ST_NOFRAMES) refusals++;
      if (out_status == ST_IGNORED) ignored_frees++;
      if (due_results.size() == 0) begin
        $display("%0t: result with none due: status %0d frame %0d last %0d",
                 $time, out_status, out_frame_res, out_last);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.status || out_frame_res !== want.frame_res ||
            out_last !== want.last) begin
          $display("%0t: result mismatch: expected status %0d frame %0d last %0d,",
                   $time, want.status, want.frame_res, want.last);
          $display("%0t:   got status %0d frame %0d last %0d",
                   $time, out_status, out_frame_res, out_last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends a run that stops moving on both channels.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: nothing accepted for %0d cycles, %0d results still due",
             $time, WATCHDOG_LIMIT, due_results.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    directed_row_t       row;
    logic [OP_W-1:0]     op;
    logic [FRAME_W-1:0]  frame;
    logic [COUNT_W-1:0]  count;
    int                  roll;
    int                  idx;
    int                  lo;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_INIT;
    in_frame      = '0;
    in_count      = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    idle_mode     = IDLE_NONE;
    quiet_cycles  = 0;
    mismatches    = 0;
    requests_sent = 0;
    results_seen  = 0;
    refusals      = 0;
    ignored_frees = 0;
    // The map after reset: the first RESERVED_RST frames used, the rest free.
    reserved_cfg = RESERVED_RST;
    for (int i = 0; i < FRAME_COUNT; i++) frame_used[i] = (i < RESERVED_RST);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, with both sides always ready. The first request waits out the
    // clearing sweep after reset on in_ready alone.
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED[r];
      send_request(row.op, row.frame, row.count, row.typed,
                   '{row.status, row.frame_res, 1'b1});
    end

    // Random phases. Each one starts from a drained, settled block with its reserved count
    // written, and with even odds it starts with an init so the written count shapes the map.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_and_configure(PHASE_RESERVED[p]);
      @(posedge clk);
      idle_mode = PHASE_IDLE[p];
      if ($urandom_range(1) == 1) send_request(OP_INIT, '0, '0, 1'b0, '0);
      for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
        // Now and then the sender holds back until the block has answered everything.
        if ($urandom_range(39) == 0) wait_drained();
        roll  = $urandom_range(99);
        frame = FRAME_W'($urandom_range(FRAME_COUNT - 1));
        count = COUNT_W'($urandom_range(16, 1));
        if (roll < 4) begin
          op = OP_INIT;
        end else if (roll < 7) begin
          op = OP_UNUSED;
        end else if (roll < 52) begin
          op = OP_ALLOC;
          // A few zero and oversized counts among mostly legal batches.
          if ($urandom_range(19) == 0)
            count = ($urandom_range(1) == 1) ? 5'd0 : COUNT_W'($urandom_range(31, 17));
        end else begin
          op   = OP_FREE;
          roll = $urandom_range(99);
          lo   = (reserved_cfg > FRAME_COUNT - 1) ? FRAME_COUNT - 1 : int'(reserved_cfg);
          if (roll < 60 && granted_frames.size() != 0) begin
            // Return a frame that is really held, so the map churns instead of filling.
            idx   = $urandom_range(granted_frames.size() - 1);
            frame = FRAME_W'(granted_frames[idx]);
            granted_frames.delete(idx);
          end else if (roll < 85) begin
            frame = FRAME_W'($urandom_range(FRAME_COUNT - 1, lo));
          end
        end
        send_request(op, frame, count, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d results across %0d reserved-count settings,",
             requests_sent, results_seen, NUM_PHASES + 1);
    $display("with %0d refused allocations, %0d ignored frees and %0d mismatches.",
             refusals, ignored_frees, mismatches);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ----- strided_frame_allocator.f -----
rtl/core/sfa_pkg.sv
rtl/core/sfa_dpath.sv
rtl/core/sfa_ctrl.sv
rtl/core/strided_frame_allocator.sv
bench/tb_strided_frame_allocator.sv
